@@ sv/fba_pkg.sv @@
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants, codes and controller/datapath interface types for the
// frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = $clog2(WORD_BITS);
    localparam int NUM_WORDS  = MAX_FRAMES / WORD_BITS;
    localparam int ADDR_W     = $clog2(NUM_WORDS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int FRAME_W    = 12;
    localparam int CFG_W      = 13;
    localparam int STATUS_W   = 2;
    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 3;

    localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = CFG_W'(MAX_FRAMES);
    localparam logic [FRAME_W:0]   MAX_FRAMES_X    = MAX_FRAMES[FRAME_W:0];

    // register index
    localparam logic REG_FRAME_COUNT = 1'b0;

    // command field
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SKIP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        RES_KEEP,   // alloc on a mapped page: hand the frame back
        RES_SKIP,   // free of frame zero
        RES_FULL,
        RES_ALLOC,
        RES_FREED
    } res_op_t;

    typedef struct packed {
        logic    capture;
        logic    init_scan;
        logic    scan_rd;
        logic    free_rd;
        logic    free_wr;
        logic    alloc_wr;
        logic    res_we;
        res_op_t res_op;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic frame_zero;
        logic in_range;
        logic found;
        logic exhausted;
        logic slot_free;
    } dp_stat_t;

endpackage

@@ sv/fba_ctrl.sv @@
// ----------------------------------------------------------------------------
// fba_ctrl
// Sequencer: dispatches each item, runs the bitmap scan or the free
// read-modify-write, and hands the result to the output register.
// ----------------------------------------------------------------------------
module fba_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  fba_pkg::dp_stat_t stat,
    output fba_pkg::dp_cmd_t  cmd
);
    import fba_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_FREE_WR  = 3'd3;
    localparam logic [2:0] S_FINISH   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_op = RES_SKIP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!stat.is_free)
                begin
                    if (!stat.frame_zero)
                    begin
                        cmd.res_we = 1'b1;
                        cmd.res_op = RES_KEEP;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.init_scan = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
                else if (stat.frame_zero)
                begin
                    cmd.res_we = 1'b1;
                    cmd.res_op = RES_SKIP;
                    state_next = S_FINISH;
                end
                else if (!stat.in_range)
                begin
                    cmd.res_we = 1'b1;
                    cmd.res_op = RES_FREED;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.free_rd = 1'b1;
                    state_next  = S_FREE_WR;
                end
            end
            S_FREE_WR:
            begin
                cmd.free_wr = 1'b1;
                cmd.res_we  = 1'b1;
                cmd.res_op  = RES_FREED;
                state_next  = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (stat.found)
                begin
                    cmd.alloc_wr = 1'b1;
                    cmd.res_we   = 1'b1;
                    cmd.res_op   = RES_ALLOC;
                    state_next   = S_FINISH;
                end
                else if (stat.exhausted)
                begin
                    cmd.res_we = 1'b1;
                    cmd.res_op = RES_FULL;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/fba_datapath.sv @@
// ----------------------------------------------------------------------------
// fba_datapath
// Bitmap memory with per-word valid bits, scan counters, lowest-zero finder,
// result staging and the output register.
// ----------------------------------------------------------------------------
module fba_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fba_pkg::dp_cmd_t              cmd,
    output fba_pkg::dp_stat_t             stat,
    input  logic [fba_pkg::CFG_W-1:0]     frame_count,
    input  logic                          command,
    input  logic [fba_pkg::FRAME_W-1:0]   page_frame,
    input  logic                          kernel_page,
    input  logic                          writable_page,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fba_pkg::FRAME_W-1:0]   new_frame,
    output logic                          present_bit,
    output logic                          write_bit,
    output logic                          user_bit,
    output logic [fba_pkg::STATUS_W-1:0]  status
);
    import fba_pkg::*;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] word_valid_reg;

    // captured item
    logic                 cmd_reg;
    logic [FRAME_W-1:0]   pf_reg;
    logic                 kern_reg;
    logic                 wr_reg;

    logic [CNT_W-1:0]     issue_reg;
    logic [ADDR_W-1:0]    chk_addr_reg;
    logic                 rd_pend_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    logic [FRAME_W-1:0]   res_frame_reg;
    logic                 res_p_reg;
    logic                 res_w_reg;
    logic                 res_u_reg;
    logic [STATUS_W-1:0]  res_st_reg;

    logic [FRAME_W-1:0]   res_frame_next;
    logic                 res_p_next;
    logic                 res_w_next;
    logic                 res_u_next;
    logic [STATUS_W-1:0]  res_st_next;

    logic                 out_valid_reg;
    logic [FRAME_W-1:0]   out_frame_reg;
    logic                 out_p_reg;
    logic                 out_w_reg;
    logic                 out_u_reg;
    logic [STATUS_W-1:0]  out_st_reg;

    logic [CNT_W-1:0]      words;
    logic                  scan_issue;
    logic                  mem_re;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  mem_we;
    logic [ADDR_W-1:0]     wr_addr;
    logic [WORD_BITS-1:0]  wr_data;
    logic [WORD_BITS-1:0]  word_eff;
    logic [WORD_SHIFT-1:0] zero_pos;
    logic                  word_full;
    logic [ADDR_W-1:0]     pf_word;
    logic [WORD_SHIFT-1:0] pf_bit;

    // partial last word is not searched; oversized count saturates
    assign words = (frame_count >= FRAME_COUNT_RST) ? CNT_W'(NUM_WORDS)
                                                    : CNT_W'(frame_count >> WORD_SHIFT);

    assign pf_word = pf_reg[FRAME_W-1:WORD_SHIFT];
    assign pf_bit  = pf_reg[WORD_SHIFT-1:0];

    assign scan_issue = cmd.scan_rd && (issue_reg < words);
    assign mem_re     = scan_issue || cmd.free_rd;
    assign rd_addr    = cmd.free_rd ? pf_word : issue_reg[ADDR_W-1:0];

    // never-written words read as free
    assign word_eff  = rd_valid_reg ? rd_data_reg : '0;
    assign word_full = (word_eff == '1);

    always_comb
    begin
        zero_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!word_eff[b])
            begin
                zero_pos = WORD_SHIFT'(b);
            end
        end
    end

    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = chk_addr_reg;
        wr_data = word_eff | (WORD_BITS'(1) << zero_pos);
        if (cmd.alloc_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.free_wr)
        begin
            mem_we  = 1'b1;
            wr_addr = pf_word;
            wr_data = word_eff & ~(WORD_BITS'(1) << pf_bit);
        end
    end

    always_comb
    begin
        res_frame_next = '0;
        res_p_next     = 1'b0;
        res_w_next     = 1'b0;
        res_u_next     = 1'b0;
        res_st_next    = ST_DONE;
        case (cmd.res_op)
            RES_KEEP:
            begin
                res_frame_next = pf_reg;
                res_st_next    = ST_SKIP;
            end
            RES_SKIP:
            begin
                res_st_next = ST_SKIP;
            end
            RES_FULL:
            begin
                res_st_next = ST_FULL;
            end
            RES_ALLOC:
            begin
                res_frame_next = {chk_addr_reg, zero_pos};
                res_p_next     = 1'b1;
                res_w_next     = wr_reg;
                res_u_next     = ~kern_reg;
            end
            default:
            begin
                res_st_next = ST_DONE;
            end
        endcase
    end

    assign stat.is_free    = (cmd_reg == CMD_FREE);
    assign stat.frame_zero = (pf_reg == '0);
    assign stat.in_range   = ({1'b0, pf_reg} < MAX_FRAMES_X);
    assign stat.found      = rd_pend_reg && !word_full;
    assign stat.exhausted  = !rd_pend_reg && (issue_reg >= words);
    assign stat.slot_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= word_valid_reg[rd_addr];
        end
        if (scan_issue)
        begin
            chk_addr_reg <= issue_reg[ADDR_W-1:0];
        end
        if (cmd.capture)
        begin
            cmd_reg  <= command;
            pf_reg   <= page_frame;
            kern_reg <= kernel_page;
            wr_reg   <= writable_page;
        end
        if (cmd.res_we)
        begin
            res_frame_reg <= res_frame_next;
            res_p_reg     <= res_p_next;
            res_w_reg     <= res_w_next;
            res_u_reg     <= res_u_next;
            res_st_reg    <= res_st_next;
        end
        if (cmd.out_load)
        begin
            out_frame_reg <= res_frame_reg;
            out_p_reg     <= res_p_reg;
            out_w_reg     <= res_w_reg;
            out_u_reg     <= res_u_reg;
            out_st_reg    <= res_st_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            issue_reg      <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                word_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.init_scan)
            begin
                issue_reg <= '0;
            end
            else if (scan_issue)
            begin
                issue_reg <= issue_reg + CNT_W'(1);
            end
            rd_pend_reg <= scan_issue;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign new_frame   = out_frame_reg;
    assign present_bit = out_p_reg;
    assign write_bit   = out_w_reg;
    assign user_bit    = out_u_reg;
    assign status      = out_st_reg;

endmodule

@@ sv/frame_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit page frame allocator over a one-bit-per-frame bitmap.
//
//   channel  signals                                  direction
//   in       in_valid/in_stall, command, page_frame,  item in
//            kernel_page, writable_page
//   out      out_valid/out_stall, new_frame,          item out
//            present_bit, write_bit, user_bit, status
//   cfg      psel/penable/pwrite/paddr/pwdata/prdata   register access
//
// One item at a time: the item is captured and dispatched, and a skipped
// item goes straight on to the output register; a free reads and rewrites
// one bitmap word, an allocate reads bitmap words up to the one with a
// clear bit, and a search that finds none reads all W = frame_count/32
// words (128 at most). The scan reads one word a cycle.
// Reset clears the bitmap at once through per-word valid bits; no sweep.
// A result held by out_stall blocks only the next item's hand-off.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [fba_pkg::FRAME_W-1:0]   page_frame,
    input  logic                          kernel_page,
    input  logic                          writable_page,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fba_pkg::FRAME_W-1:0]   new_frame,
    output logic                          present_bit,
    output logic                          write_bit,
    output logic                          user_bit,
    output logic [fba_pkg::STATUS_W-1:0]  status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fba_pkg::PADDR_W-1:0]   paddr,
    input  logic [fba_pkg::DATA_W-1:0]    pwdata,
    output logic [fba_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import fba_pkg::*;

    logic [CFG_W-1:0] frame_count_reg;
    logic             reg_sel;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_FRAME_COUNT);
    assign prdata  = reg_sel ? DATA_W'(frame_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FRAME_COUNT_RST;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            frame_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    fba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    fba_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .frame_count   (frame_count_reg),
        .command       (command),
        .page_frame    (page_frame),
        .kernel_page   (kernel_page),
        .writable_page (writable_page),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .new_frame     (new_frame),
        .present_bit   (present_bit),
        .write_bit     (write_bit),
        .user_bit      (user_bit),
        .status        (status)
    );

endmodule
